// File: design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brf assertion failed");

// next-cycle implication, checked outside reset
`define BRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brf assertion failed");

`endif

// File: design/brf_pkg.sv
// shared types and constants of the byte ring fifo
// no dependencies
`default_nettype none

package brf_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int MAX_REQUEST = 64;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int REQ_W       = 7;
  localparam int REM_W       = $clog2(MAX_REQUEST + 1);

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_REMOVE  = 2'd2,
    ACT_DISCARD = 2'd3
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              flush;
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] byte_in;
  } chain_cmd_t;

endpackage

`default_nettype wire

// File: design/byte_ring_fifo.sv
// top level of the byte fifo: sequencer plus the row of storage cells
// depends on brf_pkg, brf_ctrl, brf_chain
//
// Byte FIFO built as a row of STORE_DEPTH cells; bytes enter at the first free
// cell and the whole row shifts one cell toward the head on every removal, so
// the word delivered always comes from the head cell. Clear and add each give
// one result word. Remove and discard give n = min(request_count clipped to
// 64, bytes held) result words, one result word per cycle while the result
// register is not stalled, since the row shifts by one cell per removal; an
// empty fifo, a zero request or a refused add still gives one result word.
// A new input word is taken once the previous one has issued its last result
// and the result register is free or being read. No clearing pass follows
// reset. The capacity register is written only while no removal burst is
// running, and a write empties the fifo.
`default_nettype none

module byte_ring_fifo (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [1:0]                  in_action,
  input  wire [brf_pkg::BYTE_W-1:0]  in_data_in,
  input  wire [brf_pkg::REQ_W-1:0]   in_request_count,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [brf_pkg::BYTE_W-1:0] out_data_out,
  output logic                       out_data_valid,
  output logic                       out_accepted,
  output logic                       out_last,
  output logic [brf_pkg::CNT_W-1:0]  out_used_count,
  output logic [brf_pkg::CNT_W-1:0]  out_free_count,
  output logic                       out_is_full,
  output logic                       out_is_empty,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [8:0]                  cfg_capacity_in_use
);
  import brf_pkg::*;

  chain_cmd_t        cmd;
  logic [BYTE_W-1:0] head_data;

  brf_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_data_in          (in_data_in),
    .in_request_count    (in_request_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_out        (out_data_out),
    .out_data_valid      (out_data_valid),
    .out_accepted        (out_accepted),
    .out_last            (out_last),
    .out_used_count      (out_used_count),
    .out_free_count      (out_free_count),
    .out_is_full         (out_is_full),
    .out_is_empty        (out_is_empty),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .head_data           (head_data),
    .cmd                 (cmd)
  );

  brf_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .head_data (head_data)
  );

endmodule

`default_nettype wire

// File: design/brf_cell.sv
// one storage cell of the byte chain: an occupied flag and one byte
// depends on brf_pkg
`default_nettype none

module brf_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  brf_pkg::chain_cmd_t       cmd,
  input  wire                       prev_occ,
  input  wire                       next_occ,
  input  wire [brf_pkg::BYTE_W-1:0] next_data,
  output logic                      occ,
  output logic [brf_pkg::BYTE_W-1:0] data
);
  import brf_pkg::*;

  logic              occ_r, occ_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;

  always_comb begin
    occ_nxt  = occ_r;
    data_nxt = data_r;
    if (cmd.flush) begin
      occ_nxt = 1'b0;
    end else if (cmd.pop) begin
      // shift toward the head
      occ_nxt  = next_occ;
      data_nxt = next_data;
    end else if (cmd.push && !occ_r && prev_occ) begin
      // first empty cell takes the word
      occ_nxt  = 1'b1;
      data_nxt = cmd.byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign occ  = occ_r;
  assign data = data_r;

endmodule

`default_nettype wire

// File: design/brf_chain.sv
// row of storage cells forming the fifo body, head at cell zero
// depends on brf_pkg and brf_cell
`default_nettype none

module brf_chain (
  input  wire                        clk,
  input  wire                        rst_n,
  input  brf_pkg::chain_cmd_t        cmd,
  output logic [brf_pkg::BYTE_W-1:0] head_data
);
  import brf_pkg::*;

  logic              occ  [STORE_DEPTH];
  logic [BYTE_W-1:0] data [STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic              prev_occ;
    logic              next_occ;
    logic [BYTE_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ[i-1];
    end

    if (i == STORE_DEPTH - 1) begin : g_tail
      assign next_occ  = 1'b0;
      assign next_data = '0;
    end else begin : g_body
      assign next_occ  = occ[i+1];
      assign next_data = data[i+1];
    end

    brf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .prev_occ  (prev_occ),
      .next_occ  (next_occ),
      .next_data (next_data),
      .occ       (occ[i]),
      .data      (data[i])
    );
  end

  assign head_data = data[0];

endmodule

`default_nettype wire

// File: design/brf_ctrl.sv
// sequencer, fill count, capacity register and result register of the byte fifo
// depends on brf_pkg
`default_nettype none

module brf_ctrl (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire [1:0]                  in_action,
  input  wire [brf_pkg::BYTE_W-1:0]  in_data_in,
  input  wire [brf_pkg::REQ_W-1:0]   in_request_count,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic [brf_pkg::BYTE_W-1:0] out_data_out,
  output logic                       out_data_valid,
  output logic                       out_accepted,
  output logic                       out_last,
  output logic [brf_pkg::CNT_W-1:0]  out_used_count,
  output logic [brf_pkg::CNT_W-1:0]  out_free_count,
  output logic                       out_is_full,
  output logic                       out_is_empty,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [8:0]                  cfg_capacity_in_use,
  input  wire [brf_pkg::BYTE_W-1:0]  head_data,
  output brf_pkg::chain_cmd_t        cmd
);
  import brf_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  cap_r, cap_sat;
  logic [REM_W-1:0]  remain_r, remain_nxt;
  logic              keep_r;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_dvalid_r, out_acc_r, out_last_r;
  logic [CNT_W-1:0]  out_used_r, out_free_r;
  logic              out_full_r, out_empty_r;

  logic              out_free, in_acc, cfg_wr, load;
  logic              keep_now;
  action_t           act;
  logic [REQ_W-1:0]  req_sat;
  logic [CNT_W-1:0]  req_ext, take;
  logic [BYTE_W-1:0] r_data;
  logic              r_dvalid, r_acc, r_last;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr   = cfg_valid && cfg_ready;
  assign act      = action_t'(in_action);
  assign keep_now = (act == ACT_REMOVE);

  always_comb begin
    if (cfg_capacity_in_use == '0) begin
      cap_sat = CNT_W'(1);
    end else if (CNT_W'(cfg_capacity_in_use) > CNT_W'(STORE_DEPTH)) begin
      cap_sat = CNT_W'(STORE_DEPTH);
    end else begin
      cap_sat = CNT_W'(cfg_capacity_in_use);
    end
  end

  // words actually moved: request clipped to the limit and to the fill
  always_comb begin
    if (in_request_count > REQ_W'(MAX_REQUEST)) begin
      req_sat = REQ_W'(MAX_REQUEST);
    end else begin
      req_sat = in_request_count;
    end
    req_ext = CNT_W'(req_sat);
    take    = (req_ext < used_r) ? req_ext : used_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (act == ACT_REMOVE || act == ACT_DISCARD) && take > CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free && remain_r == REM_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: chain command and next result word
  always_comb begin
    cmd        = '0;
    load       = 1'b0;
    r_data     = '0;
    r_dvalid   = 1'b0;
    r_acc      = 1'b0;
    r_last     = 1'b0;
    used_nxt   = used_r;
    remain_nxt = remain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          load   = 1'b1;
          r_last = 1'b1;
          unique case (act) inside
            ACT_CLEAR: begin
              cmd.flush = 1'b1;
              used_nxt  = '0;
              r_acc     = 1'b1;
            end
            ACT_ADD: begin
              if (used_r != cap_r) begin
                cmd.push    = 1'b1;
                cmd.byte_in = in_data_in;
                used_nxt    = used_r + CNT_W'(1);
                r_acc       = 1'b1;
              end
            end
            ACT_REMOVE, ACT_DISCARD: begin
              if (take != '0) begin
                cmd.pop    = 1'b1;
                used_nxt   = used_r - CNT_W'(1);
                r_acc      = 1'b1;
                r_dvalid   = keep_now;
                r_data     = keep_now ? head_data : '0;
                r_last     = (take == CNT_W'(1));
                remain_nxt = REM_W'(take - CNT_W'(1));
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load       = 1'b1;
          cmd.pop    = 1'b1;
          used_nxt   = used_r - CNT_W'(1);
          r_acc      = 1'b1;
          r_dvalid   = keep_r;
          r_data     = keep_r ? head_data : '0;
          r_last     = (remain_r == REM_W'(1));
          remain_nxt = remain_r - REM_W'(1);
        end
      end
      default: ;
    endcase
    // capacity write empties the fifo
    if (cfg_wr) begin
      cmd.flush = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      cap_r       <= CNT_W'(STORE_DEPTH);
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
      if (cfg_wr) begin
        used_r <= '0;
        cap_r  <= cap_sat;
      end else begin
        used_r <= used_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      keep_r <= keep_now;
    end
    if (load) begin
      out_data_r   <= r_data;
      out_dvalid_r <= r_dvalid;
      out_acc_r    <= r_acc;
      out_last_r   <= r_last;
      out_used_r   <= used_nxt;
      out_free_r   <= cap_r - used_nxt;
      out_full_r   <= (used_nxt == cap_r);
      out_empty_r  <= (used_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_data_valid = out_dvalid_r;
  assign out_accepted   = out_acc_r;
  assign out_last       = out_last_r;
  assign out_used_count = out_used_r;
  assign out_free_count = out_free_r;
  assign out_is_full    = out_full_r;
  assign out_is_empty   = out_empty_r;

endmodule

`default_nettype wire

// File: design/brf_checker.sv
// port-level checks of the byte fifo, bound to the top level
// depends on brf_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module brf_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_stall,
  input wire                       out_valid,
  input wire                       out_stall,
  input wire [brf_pkg::BYTE_W-1:0] out_data_out,
  input wire                       out_data_valid,
  input wire                       out_accepted,
  input wire                       out_last,
  input wire                       out_is_full,
  input wire                       out_is_empty,
  input wire                       cfg_ready
);
  import brf_pkg::*;

  // a delivered byte always counts as a moved word
  `BRF_ASSERT_IMP(a_dvalid_acc, clk, rst_n, out_valid && out_data_valid, out_accepted)
  // full and empty exclude each other
  `BRF_ASSERT_IMP(a_full_empty, clk, rst_n, out_valid, !(out_is_full && out_is_empty))
  // no new word or capacity write while a burst is unfinished
  `BRF_ASSERT_IMP(a_burst_block, clk, rst_n, out_valid && !out_last, in_stall && !cfg_ready)
  // a taken mid-burst word is followed at once by the next one
  `BRF_ASSERT_NXT(a_burst_cont, clk, rst_n, out_valid && !out_last && !out_stall, out_valid)
  // a stalled result holds
  `BRF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_data_out) && $stable(out_last))

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (.*);

`default_nettype wire
